[src/tlq_pkg.sv]
package tlq_pkg;

  localparam int unsigned NodeW = 11;

  // function codes of a request
  localparam logic [1:0] FuncEdge  = 2'd0;
  localparam logic [1:0] FuncBuild = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [NodeW-1:0] first_node;
    logic [NodeW-1:0] second_node;
  } tlq_req_t;

  typedef struct packed {
    logic [NodeW-1:0] ancestor;
    logic             bad_node;
  } tlq_rsp_t;

endpackage

[src/tree_lca_query_engine.sv]
// tree lowest common ancestor engine, one request at a time, stall high while busy
// edge request: states E1 to E4 append two directed entries; build: clears visited marks
// over all nodes, then walks breadth first from node 1 over the stored edge entries
// query: result after reading depths and climbing, straight to the result for a bad node;
// a result still waiting in the output register holds the next query at its end
// reset clears the list heads by a sweep over all nodes, no request accepted then
module tree_lca_query_engine
  import tlq_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [NodeW-1:0]    cfg_wdata_i,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  tlq_req_t            req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output tlq_rsp_t            rsp_o
);

  localparam int unsigned NA = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned EdgeCap = 2 * (MAX_NODES - 1);
  localparam int unsigned EA = $clog2(EdgeCap);
  localparam int unsigned EW = EA + 1;
  localparam int unsigned CW = NA + 1;
  localparam int unsigned DW = NA;
  localparam int unsigned SW = CW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_E1, S_E2, S_E3, S_E4,
    S_BCLR, S_BDEQ, S_BHEAD, S_BHEADW, S_BEDGE, S_BEDGEW, S_BVIS, S_BVISW,
    S_QD, S_QDW, S_QLIFT, S_QLIFTW, S_QRESULT
  } state_e;

  // memories
  logic [EW-1:0]    head_mem [MAX_NODES];
  logic [EW-1:0]    tail_mem [MAX_NODES];
  logic [NodeW-1:0] tgt_mem  [EdgeCap];
  logic [EW-1:0]    link_mem [EdgeCap];
  logic [NodeW-1:0] par_mem  [MAX_NODES];
  logic [DW-1:0]    dep_mem  [MAX_NODES];
  logic             vis_mem  [MAX_NODES];
  logic [NodeW-1:0] que_mem  [MAX_NODES];

  state_e           state_q;
  logic [NodeW-1:0] ncount_q;
  logic [EW-1:0]    ecount_q;
  logic [CW-1:0]    sweep_q;
  logic [NodeW-1:0] a_q, b_q;
  logic [DW-1:0]    da_q, db_q, dcur_q;
  logic [EW-1:0]    e_q, h_q;
  logic [1:0]       pass_q;
  logic [CW-1:0]    qh_q, qt_q;
  logic [NodeW-1:0] cur_q, nxt_q;
  logic [SW-1:0]    steps_q;
  logic [1:0]       phase_q;
  logic             bad_q;
  logic             rvalid_q;
  tlq_rsp_t         rsp_q;

  // registered read data
  logic [EW-1:0]    head_rd_q, tail_rd_q, link_rd_q;
  logic [NodeW-1:0] tgt_rd_q, par_a_q, par_b_q, que_rd_q;
  logic [DW-1:0]    dep_a_q, dep_b_q;
  logic             vis_rd_q;

  logic [NodeW-1:0] nuse;
  logic             a_ok, b_ok;
  logic [EW-1:0]    empty_c;

  assign empty_c = {EW{1'b1}};

  // clamp of node count register
  always_comb begin
    if (ncount_q == '0) nuse = NodeW'(1);
    else if (32'(ncount_q) > MAX_NODES) nuse = NodeW'(MAX_NODES);
    else nuse = ncount_q;
  end
  assign a_ok = (req_i.first_node != '0) && (req_i.first_node <= nuse);
  assign b_ok = (req_i.second_node != '0) && (req_i.second_node <= nuse);

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rvalid_q;
  assign rsp_o       = rsp_q;

  function automatic logic [NA-1:0] nidx(input logic [NodeW-1:0] n);
    logic [NodeW-1:0] m;
    m = n - NodeW'(1);
    return m[NA-1:0];
  endfunction

  // memory reads, addressed by node, edge and queue registers
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[nidx(a_q)];
    tail_rd_q <= tail_mem[nidx(a_q)];
    link_rd_q <= link_mem[e_q[EA-1:0]];
    tgt_rd_q  <= tgt_mem[e_q[EA-1:0]];
    par_a_q   <= par_mem[nidx(a_q)];
    par_b_q   <= par_mem[nidx(b_q)];
    dep_a_q   <= dep_mem[nidx(a_q)];
    dep_b_q   <= dep_mem[nidx(b_q)];
    vis_rd_q  <= vis_mem[nidx(tgt_rd_q)];
    que_rd_q  <= que_mem[qh_q[NA-1:0]];
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLEAR: head_mem[sweep_q[NA-1:0]] <= empty_c;
      S_E1, S_E4: link_mem[e_q[EA-1:0]] <= empty_c;
      S_E2: begin
        tgt_mem[e_q[EA-1:0]]  <= b_q;
        if (head_rd_q == empty_c) head_mem[nidx(a_q)] <= e_q;
        else link_mem[tail_rd_q[EA-1:0]] <= e_q;
        tail_mem[nidx(a_q)] <= e_q;
      end
      S_BCLR: begin
        vis_mem[sweep_q[NA-1:0]] <= (sweep_q == '0);
        if (sweep_q == '0) begin
          dep_mem[0] <= '0;
          par_mem[0] <= '0;
          que_mem[0] <= NodeW'(1);
        end
      end
      S_BVISW: begin
        if (nxt_q != '0 && 32'(nxt_q) <= MAX_NODES && !vis_rd_q
            && 32'(qt_q) < MAX_NODES) begin
          vis_mem[nidx(nxt_q)] <= 1'b1;
          que_mem[qt_q[NA-1:0]] <= nxt_q;
          par_mem[nidx(nxt_q)]  <= cur_q;
          dep_mem[nidx(nxt_q)]  <= dcur_q + DW'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ncount_q <= NodeW'(1);
      ecount_q <= '0;
      sweep_q  <= '0;
      rvalid_q <= 1'b0;
      a_q <= '0; b_q <= '0; e_q <= '0; cur_q <= '0; nxt_q <= '0;
      qh_q <= '0; qt_q <= '0; pass_q <= '0; phase_q <= '0; steps_q <= '0;
      da_q <= '0; db_q <= '0; dcur_q <= '0; h_q <= '0; bad_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      if (cfg_we_i) ncount_q <= cfg_wdata_i;
      if (rvalid_q && !rsp_stall_i && state_q != S_QRESULT) rvalid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (32'(sweep_q) == MAX_NODES - 1) state_q <= S_IDLE;
          sweep_q <= sweep_q + CW'(1);
        end
        S_IDLE: begin
          if (req_valid_i) begin
            a_q <= req_i.first_node;
            b_q <= req_i.second_node;
            case (req_i.func)
              FuncEdge: begin
                if (a_ok && b_ok && 32'(ecount_q) + 2 <= EdgeCap) begin
                  e_q <= ecount_q;
                  pass_q <= 2'd0;
                  state_q <= S_E1;
                end
              end
              FuncBuild: begin
                sweep_q <= '0;
                state_q <= S_BCLR;
              end
              FuncQuery: begin
                if (!a_ok || !b_ok) begin
                  bad_q <= 1'b1;
                  state_q <= S_QRESULT;
                end else begin
                  bad_q <= 1'b0;
                  phase_q <= 2'd0;
                  steps_q <= '0;
                  state_q <= S_QD;
                end
              end
              default: ;
            endcase
          end
        end
        // edge append, two directed entries
        S_E1: state_q <= S_E2;
        S_E2: begin
          e_q <= e_q + EW'(1);
          if (pass_q == 2'd0) begin
            pass_q <= 2'd1;
            a_q <= b_q;
            b_q <= a_q;
            state_q <= S_E3;
          end else begin
            ecount_q <= e_q + EW'(1);
            state_q <= S_IDLE;
          end
        end
        S_E3: state_q <= S_E4;
        S_E4: state_q <= S_E2;
        // build: clear marks, then breadth first walk
        S_BCLR: begin
          if (32'(sweep_q) == MAX_NODES - 1) begin
            qh_q <= '0;
            qt_q <= CW'(1);
            state_q <= S_BDEQ;
          end
          sweep_q <= sweep_q + CW'(1);
        end
        S_BDEQ: begin
          if (qh_q == qt_q) state_q <= S_IDLE;
          else state_q <= S_BHEAD;
        end
        S_BHEAD: begin
          cur_q <= que_rd_q;
          a_q <= que_rd_q;
          qh_q <= qh_q + CW'(1);
          state_q <= S_BHEADW;
        end
        S_BHEADW: begin
          // head and depth of the current node are read in this state
          state_q <= S_BEDGE;
        end
        S_BEDGE: begin
          dcur_q <= dep_a_q;
          e_q <= head_rd_q;
          state_q <= S_BEDGEW;
        end
        S_BEDGEW: begin
          if (e_q == empty_c || 32'(e_q) >= EdgeCap) state_q <= S_BDEQ;
          else state_q <= S_BVIS;
        end
        S_BVIS: begin
          nxt_q <= tgt_rd_q;
          h_q <= link_rd_q;
          state_q <= S_BVISW;
        end
        S_BVISW: begin
          if (nxt_q != '0 && 32'(nxt_q) <= MAX_NODES && !vis_rd_q
              && 32'(qt_q) < MAX_NODES)
            qt_q <= qt_q + CW'(1);
          e_q <= h_q;
          state_q <= S_BEDGEW;
        end
        // query: read depths, then climb
        S_QD: state_q <= S_QDW;
        S_QDW: begin
          da_q <= (a_q == '0) ? '0 : dep_a_q;
          db_q <= (b_q == '0) ? '0 : dep_b_q;
          state_q <= S_QLIFT;
        end
        S_QLIFT: begin
          logic go;
          go = 1'b0;
          case (phase_q)
            2'd0: go = da_q > db_q;
            2'd1: go = db_q > da_q;
            default: go = a_q != b_q;
          endcase
          if (go && 32'(steps_q) < MAX_NODES) begin
            state_q <= S_QLIFTW;
          end else if (phase_q == 2'd2) begin
            state_q <= S_QRESULT;
          end else begin
            phase_q <= phase_q + 2'd1;
            steps_q <= '0;
          end
        end
        S_QLIFTW: begin
          steps_q <= steps_q + SW'(1);
          if (phase_q != 2'd1) a_q <= (a_q == '0) ? '0 : par_a_q;
          if (phase_q != 2'd0) b_q <= (b_q == '0) ? '0 : par_b_q;
          state_q <= S_QD;
        end
        // result waits until the output register is free
        S_QRESULT: begin
          if (!rvalid_q || !rsp_stall_i) begin
            if (bad_q) rsp_q <= '{ancestor: '0, bad_node: 1'b1};
            else rsp_q <= '{ancestor: (a_q == b_q) ? a_q : '0, bad_node: 1'b0};
            rvalid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tree_lca_query_engine_tb.sv]
module tree_lca_query_engine_tb;
  import tlq_pkg::*;

  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned EdgeCap    = 2 * (MaxNodes - 1);
  localparam int unsigned NoEntry    = 32'hFFFF_FFFF;
  localparam logic [1:0]  FuncNone   = 2'd3;
  localparam int unsigned SettleWait = 6 * MaxNodes + 3 * EdgeCap + 256;
  localparam int unsigned StallLimit = 100000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [NodeW-1:0] cfg_wdata_i = '0;
  logic             req_valid_i = 1'b0;
  logic             req_stall_o;
  tlq_req_t         req_i       = '0;
  logic             rsp_valid_o;
  logic             rsp_stall_i = 1'b0;
  tlq_rsp_t         rsp_o;

  // model state of the tree tables
  int unsigned node_count_reg;
  int unsigned list_first [MaxNodes];
  int unsigned list_last  [MaxNodes];
  int unsigned link_to    [EdgeCap];
  int unsigned link_next  [EdgeCap];
  int unsigned links_used;
  int unsigned parent_tab [MaxNodes];
  int unsigned depth_tab  [MaxNodes];
  bit          ever_reached [MaxNodes];

  tlq_rsp_t ancestor_q[$];

  int unsigned n_requests, n_answers, n_builds, n_errors, n_idle;
  int unsigned hold_left, burst_left;
  bit          idle_on = 1'b1;

  tree_lca_query_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- prediction ----------------

  function automatic int unsigned nodes_live();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > MaxNodes) return MaxNodes;
    return node_count_reg;
  endfunction

  function automatic void push_link(int unsigned from, int unsigned to);
    link_to[links_used]   = to;
    link_next[links_used] = NoEntry;
    if (list_first[from-1] == NoEntry) list_first[from-1] = links_used;
    else link_next[list_last[from-1]] = links_used;
    list_last[from-1] = links_used;
    links_used++;
  endfunction

  // breadth-first walk from node 1
  function automatic void walk_tree();
    bit          seen [MaxNodes];
    int unsigned order [MaxNodes];
    int unsigned qh, qt, cur, e, nxt;
    qh = 0;
    qt = 1;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[0] = 1'b1;
    ever_reached[0] = 1'b1;
    depth_tab[0] = 0;
    parent_tab[0] = 0;
    order[0] = 1;
    while (qh < qt) begin
      cur = order[qh];
      qh++;
      e = list_first[cur-1];
      while (e != NoEntry && e < EdgeCap) begin
        nxt = link_to[e];
        if (nxt >= 1 && nxt <= MaxNodes && !seen[nxt-1] && qt < MaxNodes) begin
          seen[nxt-1] = 1'b1;
          ever_reached[nxt-1] = 1'b1;
          order[qt] = nxt;
          qt++;
          parent_tab[nxt-1] = cur;
          depth_tab[nxt-1] = depth_tab[cur-1] + 1;
        end
        e = link_next[e];
      end
    end
  endfunction

  function automatic int unsigned depth_at(int unsigned n);
    return (n == 0) ? 0 : depth_tab[n-1];
  endfunction

  function automatic int unsigned parent_at(int unsigned n);
    return (n == 0) ? 0 : parent_tab[n-1];
  endfunction

  // climb one step at a time, each phase bounded
  function automatic int unsigned climb_to_meet(int unsigned a, int unsigned b);
    for (int unsigned i = 0; i < MaxNodes && depth_at(a) > depth_at(b); i++)
      a = parent_at(a);
    for (int unsigned i = 0; i < MaxNodes && depth_at(b) > depth_at(a); i++)
      b = parent_at(b);
    for (int unsigned i = 0; i < MaxNodes && a != b; i++) begin
      a = parent_at(a);
      b = parent_at(b);
    end
    return (a == b) ? a : 0;
  endfunction

  function automatic bit apply_request(input tlq_req_t r, output tlq_rsp_t res);
    int unsigned a, b, n;
    a = r.first_node;
    b = r.second_node;
    n = nodes_live();
    res = '0;
    case (r.func)
      FuncEdge: begin
        if (a >= 1 && a <= n && b >= 1 && b <= n && links_used + 2 <= EdgeCap) begin
          push_link(a, b);
          push_link(b, a);
        end
        return 1'b0;
      end
      FuncBuild: begin
        walk_tree();
        return 1'b0;
      end
      FuncQuery: begin
        if (a < 1 || a > n || b < 1 || b > n) begin
          res.bad_node = 1'b1;
        end else begin
          res.ancestor = NodeW'(climb_to_meet(a, b));
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // a node in range that some build has reached
  function automatic int unsigned pick_reached();
    int unsigned v;
    for (int k = 0; k < 60; k++) begin
      v = $urandom_range(1, nodes_live());
      if (ever_reached[v-1]) return v;
    end
    return 1;
  endfunction

  // ---------------- driving ----------------

  task automatic send_request(input logic [1:0] f, input int unsigned a,
                              input int unsigned b);
    tlq_req_t    r;
    tlq_rsp_t    res;
    int unsigned gap;
    r.func        = f;
    r.first_node  = a[NodeW-1:0];
    r.second_node = b[NodeW-1:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (apply_request(r, res)) ancestor_q.insert(ancestor_q.size(), res);
    if (f == FuncBuild) n_builds++;
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (req_stall_o);
    n_requests++;
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (ancestor_q.size() != 0) @(posedge clk_i);
  endtask

  // register writes only when the engine is idle
  task automatic set_node_count(input int unsigned v);
    wait_drained();
    repeat (SettleWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[NodeW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_count_reg = v & 32'h7FF;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d (answer %0d)", what, got, want, n_answers);
    n_errors++;
  endtask

  // ---------------- response side ----------------

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        rsp_stall_i <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 3);
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  // response check and watchdog
  always @(posedge clk_i) begin
    tlq_rsp_t want;
    bit       moved;
    moved = 1'b0;
    if (req_valid_i && !req_stall_o) moved = 1'b1;
    if (rsp_valid_o && !rsp_stall_i) begin
      moved = 1'b1;
      if (ancestor_q.size() == 0) begin
        report_mismatch("unrequested answer", rsp_o.ancestor, 0);
      end else begin
        want = ancestor_q.pop_front();
        if (rsp_o.ancestor !== want.ancestor)
          report_mismatch("ancestor", rsp_o.ancestor, want.ancestor);
        if (rsp_o.bad_node !== want.bad_node)
          report_mismatch("bad_node", rsp_o.bad_node, want.bad_node);
      end
      n_answers++;
    end
    if (!rst_ni || moved) n_idle = 0;
    else n_idle++;
    if (n_idle >= StallLimit) begin
      $display("timeout: no request or answer moved for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- tests ----------------

  // single node, bad nodes, idle function code
  task automatic test_single_node();
    set_node_count(0);
    send_request(FuncEdge, 1, 1);
    send_request(FuncBuild, 0, 0);
    send_request(FuncQuery, 1, 1);
    send_request(FuncQuery, 0, 0);
    send_request(FuncQuery, 2047, 2047);
    send_request(FuncQuery, 2, 1);
    send_request(FuncNone, 2047, 2047);
  endtask

  // small fixed tree, dropped edges, clamped and shrunk range
  task automatic test_small_tree();
    set_node_count(8);
    send_request(FuncEdge, 1, 2);
    send_request(FuncEdge, 1, 3);
    send_request(FuncEdge, 2, 4);
    send_request(FuncEdge, 2, 5);
    send_request(FuncEdge, 5, 6);
    send_request(FuncEdge, 0, 3);
    send_request(FuncEdge, 9, 1);
    send_request(FuncBuild, 0, 0);
    send_request(FuncQuery, 6, 4);
    send_request(FuncQuery, 4, 6);
    send_request(FuncQuery, 6, 3);
    send_request(FuncQuery, 1, 6);
    send_request(FuncQuery, 9, 1);
    set_node_count(2047);
    send_request(FuncQuery, 1025, 1);
    send_request(FuncQuery, 6, 5);
    set_node_count(4);
    send_request(FuncBuild, 0, 0);
    send_request(FuncQuery, 4, 3);
    send_request(FuncQuery, 6, 1);
  endtask

  // phases of random trees, builds and queries with some noise
  task automatic test_random_trees();
    int unsigned joined[$];
    int unsigned n, a, b, k, phase;
    phase = 0;
    while (n_requests < 340) begin
      if (phase % 3 == 0) begin
        case ($urandom_range(0, 9))
          0:       set_node_count(2047);
          1:       set_node_count(1024);
          2:       set_node_count(1);
          default: set_node_count($urandom_range(2, 40));
        endcase
      end
      idle_on = ($urandom_range(0, 3) != 0);
      n = nodes_live();
      joined = {1};
      k = $urandom_range(3, 12);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(0, 9))
          0: send_request(FuncEdge, $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 2047),
                          $urandom_range(1, n));
          1: send_request(FuncNone, $urandom_range(0, 2047), $urandom_range(0, 2047));
          default: begin
            a = $urandom_range(1, n);
            b = joined[$urandom_range(0, joined.size() - 1)];
            joined.insert(joined.size(), a);
            if ($urandom_range(0, 1)) send_request(FuncEdge, a, b);
            else send_request(FuncEdge, b, a);
          end
        endcase
      end
      // now and then leave the tables stale
      if ($urandom_range(0, 5) != 0 || phase == 0) send_request(FuncBuild, 0, 0);
      k = $urandom_range(4, 15);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(FuncQuery,
                       $urandom_range(0, 1) ? pick_reached() : $urandom_range(n + 1, 2047),
                       $urandom_range(0, 1) ? 0 : pick_reached());
        else
          send_request(FuncQuery, pick_reached(), pick_reached());
      end
      phase++;
    end
  endtask

  // receiver holds off while queries keep coming, then sender waits for all answers
  task automatic test_backpressure();
    idle_on = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 20; i++) send_request(FuncQuery, pick_reached(), pick_reached());
    wait_drained();
    for (int i = 0; i < 6; i++) send_request(FuncQuery, pick_reached(), pick_reached());
  endtask

  // long chain over nodes 1 to 171 in a range of 1024, then deep climbs
  task automatic test_long_chain();
    int unsigned top;
    idle_on = 1'b0;
    set_node_count(1024);
    top = 1;
    while (top < 171) begin
      send_request(FuncEdge, top, top + 1);
      top++;
    end
    for (int i = 0; i < 4; i++) send_request(FuncEdge, $urandom_range(1, 1024), 1);
    send_request(FuncBuild, 0, 0);
    send_request(FuncQuery, top, 1);
    send_request(FuncQuery, top, top - 1);
    for (int i = 0; i < 12; i++) send_request(FuncQuery, pick_reached(), pick_reached());
  endtask

  initial begin
    node_count_reg = 1;
    links_used = 0;
    foreach (list_first[i]) begin
      list_first[i] = NoEntry;
      list_last[i] = NoEntry;
      parent_tab[i] = 0;
      depth_tab[i] = 0;
      ever_reached[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_node();
    test_small_tree();
    test_random_trees();
    test_backpressure();
    test_long_chain();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests, %0d builds, %0d answers, %0d directed edge entries",
             n_requests, n_builds, n_answers, links_used);
    $display("node counts from 0 to 2047, stale tables, deep chain, long receiver hold");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
